// File: rtl/psch_pkg.sv
// ----------------------------------------------------------------------------
// psch_pkg - shared definitions for the preemptive priority scheduler
// Table geometry, input mode codes and the packed layout of one task entry.
// ----------------------------------------------------------------------------
package psch_pkg;

  localparam int MAX_TASKS = 32;
  localparam int SLOT_W    = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  localparam int ID_W   = 8;
  localparam int TIME_W = 16;
  localparam int PRIO_W = 7;
  localparam int CLK_W  = 32;

  // Input mode codes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // One row of the task table memory
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] remaining;
    logic [CLK_W-1:0]  start;
  } task_entry_t;

endpackage

// File: rtl/preemptive_priority_scheduler.sv
// A load is written in the cycle it is accepted and gives no result.
// A tick reads the table once per slot for n slots, n being task_count held
// to 32, then does one read-modify-write and registers its result, waiting
// while the output is stalled; no new item is taken until that is done.
// Reset: time, task_count, done flags and handshake state clear; table rows
// hold no reset value and are defined once loaded.
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler - tick driven priority scheduler
// Scans the task table memory each tick, runs the highest priority eligible
// slot for one time unit, writes it back and reports completion figures.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [psch_pkg::CNT_W-1:0]    cfg_wr_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          mode,
  input  logic [psch_pkg::SLOT_W-1:0]   slot,
  input  logic [psch_pkg::ID_W-1:0]     task_id,
  input  logic [psch_pkg::TIME_W-1:0]   arrival_time,
  input  logic [psch_pkg::TIME_W-1:0]   burst_length,
  input  logic [psch_pkg::PRIO_W-1:0]   task_priority,
  // output channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [psch_pkg::CLK_W-1:0]    time_now,
  output logic                          idle,
  output logic [psch_pkg::SLOT_W-1:0]   running_slot,
  output logic [psch_pkg::ID_W-1:0]     running_id,
  output logic                          finished,
  output logic [psch_pkg::CLK_W-1:0]    start_time,
  output logic [psch_pkg::CLK_W-1:0]    end_time,
  output logic [psch_pkg::CLK_W-1:0]    waiting_time,
  output logic [psch_pkg::CLK_W-1:0]    turnaround_time,
  output logic                          all_done
);
  import psch_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0]           state;
  logic [CNT_W-1:0]     task_count;
  logic [CNT_W-1:0]     n_active;
  logic [CLK_W-1:0]     cur_time;
  logic [MAX_TASKS-1:0] done_flags;

  task_entry_t          mem [MAX_TASKS];
  task_entry_t          rd_data;
  logic [SLOT_W-1:0]    rd_addr;
  logic                 wr_en;
  logic [SLOT_W-1:0]    wr_addr;
  task_entry_t          wr_data;

  logic [CNT_W-1:0]     eval_idx;
  logic                 found;
  logic [SLOT_W-1:0]    pick;
  task_entry_t          pick_word;

  logic                 in_xfer;
  logic                 tick_xfer;
  logic                 load_xfer;
  logic                 out_free;
  logic                 upd_go;
  logic                 cand_ok;
  logic                 scan_last;
  logic [TIME_W-1:0]    load_burst;
  logic [TIME_W-1:0]    rem_dec;
  logic                 fin;
  logic [CLK_W-1:0]     start_new;
  logic [CLK_W-1:0]     end_val;
  logic [CLK_W-1:0]     turn_val;
  logic [MAX_TASKS-1:0] done_next;
  logic [MAX_TASKS-1:0] count_mask;

  // Clamp the slot count to the table depth
  assign n_active = (task_count > CNT_W'(MAX_TASKS)) ? CNT_W'(MAX_TASKS) : task_count;

  // Handshake decode
  assign in_ready  = (state == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign tick_xfer = in_xfer && (mode == MODE_TICK);
  assign load_xfer = in_xfer && (mode == MODE_LOAD);
  assign out_free  = !out_valid || out_ready;
  assign upd_go    = (state == S_UPD) && out_free;

  // Scan compare on the row returned by the memory
  assign cand_ok   = !done_flags[eval_idx[SLOT_W-1:0]]
                     && ({{(CLK_W-TIME_W){1'b0}}, rd_data.arrival} <= cur_time)
                     && (!found || (rd_data.prio < pick_word.prio));
  assign scan_last = ((eval_idx + CNT_W'(1)) == n_active);

  // Read address: slot 0 on a tick transfer, then the next slot each scan cycle
  always_comb begin
    if (state == S_SCAN) begin
      rd_addr = SLOT_W'(eval_idx + CNT_W'(1));
    end else begin
      rd_addr = '0;
    end
  end

  // Run the picked slot for one unit
  assign rem_dec   = pick_word.remaining - TIME_W'(1);
  assign fin       = found && (rem_dec == '0);
  assign start_new = (pick_word.remaining == pick_word.burst) ? cur_time : pick_word.start;
  assign end_val   = cur_time + CLK_W'(1);
  assign turn_val  = end_val - {{(CLK_W-TIME_W){1'b0}}, pick_word.arrival};

  // Done flags after this tick, and which slots take part
  always_comb begin
    done_next = done_flags;
    if (fin) begin
      done_next[pick] = 1'b1;
    end
    for (int i = 0; i < MAX_TASKS; i++) begin
      count_mask[i] = (i < int'(n_active));
    end
  end

  // Memory write port: loads from the input, write-back from the update step
  assign load_burst = (burst_length == '0) ? TIME_W'(1) : burst_length;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot;
    wr_data = pick_word;
    if (load_xfer) begin
      wr_en             = 1'b1;
      wr_addr           = slot;
      wr_data.id        = task_id;
      wr_data.arrival   = arrival_time;
      wr_data.burst     = load_burst;
      wr_data.prio      = task_priority;
      wr_data.remaining = load_burst;
      wr_data.start     = '0;
    end else if (upd_go && found) begin
      wr_en             = 1'b1;
      wr_addr           = pick;
      wr_data.remaining = rem_dec;
      wr_data.start     = start_new;
    end
  end

  // Task table memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Sequencer and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      task_count <= '0;
      cur_time   <= '0;
      done_flags <= '0;
      found      <= 1'b0;
      eval_idx   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        task_count <= cfg_wr_data;
      end
      if (out_valid && out_ready && !upd_go) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (load_xfer) begin
            done_flags[slot] <= 1'b0;
          end
          if (tick_xfer) begin
            found    <= 1'b0;
            eval_idx <= '0;
            state    <= (n_active == '0) ? S_UPD : S_SCAN;
          end
        end
        S_SCAN: begin
          if (cand_ok) begin
            found <= 1'b1;
          end
          eval_idx <= eval_idx + CNT_W'(1);
          if (scan_last) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          // hold until the output register is free
          if (out_free) begin
            done_flags <= done_next;
            cur_time   <= end_val;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Capture the best candidate seen so far
  always_ff @(posedge clk) begin
    if ((state == S_SCAN) && cand_ok) begin
      pick      <= eval_idx[SLOT_W-1:0];
      pick_word <= rd_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (upd_go) begin
      time_now        <= cur_time;
      idle            <= !found;
      running_slot    <= found ? pick : '0;
      running_id      <= found ? pick_word.id : '0;
      finished        <= fin;
      start_time      <= fin ? start_new : '0;
      end_time        <= fin ? end_val : '0;
      turnaround_time <= fin ? turn_val : '0;
      waiting_time    <= fin ? (turn_val - {{(CLK_W-TIME_W){1'b0}}, pick_word.burst}) : '0;
      all_done        <= ((done_next & count_mask) == count_mask);
    end
  end

endmodule

// File: test/tb_preemptive_priority_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_preemptive_priority_scheduler - self-checking bench for the scheduler
// Loads task slots and issues ticks over valid/ready, predicts each tick's
// report from a cycle-free model of the task table, and compares every
// report field by field. Directed cases cover ties, preemption, zero burst,
// reload and oversized task_count. Random workloads follow in three phases,
// two of them with sender and receiver stalls.
// ----------------------------------------------------------------------------
module tb_preemptive_priority_scheduler;
  import psch_pkg::*;

  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_LIMIT = 10;
  localparam int PHASE_ITEMS  = 610;

  typedef struct {
    logic [CLK_W-1:0]  time_now;
    logic              idle;
    logic [SLOT_W-1:0] running_slot;
    logic [ID_W-1:0]   running_id;
    logic              finished;
    logic [CLK_W-1:0]  start_time;
    logic [CLK_W-1:0]  end_time;
    logic [CLK_W-1:0]  waiting_time;
    logic [CLK_W-1:0]  turnaround_time;
    logic              all_done;
  } tick_report_t;

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [CNT_W-1:0]  cfg_wr_data;
  logic              in_valid;
  logic              in_ready;
  logic              mode;
  logic [SLOT_W-1:0] slot;
  logic [ID_W-1:0]   task_id;
  logic [TIME_W-1:0] arrival_time;
  logic [TIME_W-1:0] burst_length;
  logic [PRIO_W-1:0] task_priority;
  logic              out_valid;
  logic              out_ready;
  logic [CLK_W-1:0]  time_now;
  logic              idle;
  logic [SLOT_W-1:0] running_slot;
  logic [ID_W-1:0]   running_id;
  logic              finished;
  logic [CLK_W-1:0]  start_time;
  logic [CLK_W-1:0]  end_time;
  logic [CLK_W-1:0]  waiting_time;
  logic [CLK_W-1:0]  turnaround_time;
  logic              all_done;

  // Shadow task table and scheduler state
  logic [ID_W-1:0]   tbl_id        [MAX_TASKS];
  logic [TIME_W-1:0] tbl_arrival   [MAX_TASKS];
  logic [TIME_W-1:0] tbl_burst     [MAX_TASKS];
  logic [PRIO_W-1:0] tbl_prio      [MAX_TASKS];
  logic [TIME_W-1:0] tbl_remaining [MAX_TASKS];
  logic [CLK_W-1:0]  tbl_start     [MAX_TASKS];
  bit                tbl_done      [MAX_TASKS];
  logic [CLK_W-1:0]  sched_time;
  int unsigned       sched_count;
  tick_report_t      pending_reports[$];

  int send_idle_pct  = 29;
  int recv_stall_pct = 57;
  int n_items, n_loads, n_ticks, n_cfg;
  int n_results, n_completions, n_idle_ticks, n_errors;

  preemptive_priority_scheduler dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .slot           (slot),
    .task_id        (task_id),
    .arrival_time   (arrival_time),
    .burst_length   (burst_length),
    .task_priority  (task_priority),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .time_now       (time_now),
    .idle           (idle),
    .running_slot   (running_slot),
    .running_id     (running_id),
    .finished       (finished),
    .start_time     (start_time),
    .end_time       (end_time),
    .waiting_time   (waiting_time),
    .turnaround_time(turnaround_time),
    .all_done       (all_done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Write one slot: a zero burst is held at one
  function automatic void model_load(logic [SLOT_W-1:0] s, logic [ID_W-1:0] id,
                                     logic [TIME_W-1:0] arr, logic [TIME_W-1:0] bl,
                                     logic [PRIO_W-1:0] pr);
    logic [TIME_W-1:0] b;
    b = (bl == '0) ? TIME_W'(1) : bl;
    tbl_id[s]        = id;
    tbl_arrival[s]   = arr;
    tbl_burst[s]     = b;
    tbl_prio[s]      = pr;
    tbl_remaining[s] = b;
    tbl_done[s]      = 1'b0;
  endfunction

  function automatic bit table_all_done();
    bit all;
    all = 1'b1;
    for (int i = 0; i < sched_count; i++)
      if (!tbl_done[i]) all = 1'b0;
    return all;
  endfunction

  // Pick, run one unit, report and advance the time
  function automatic tick_report_t model_tick();
    tick_report_t r;
    bit found;
    int pick;
    logic [PRIO_W-1:0] best;
    found = 1'b0;
    pick  = 0;
    best  = '0;
    for (int i = 0; i < sched_count; i++) begin
      if (tbl_done[i] || CLK_W'(tbl_arrival[i]) > sched_time) continue;
      if (!found || tbl_prio[i] < best) begin
        found = 1'b1;
        best  = tbl_prio[i];
        pick  = i;
      end
    end
    r.time_now        = sched_time;
    r.idle            = !found;
    r.running_slot    = '0;
    r.running_id      = '0;
    r.finished        = 1'b0;
    r.start_time      = '0;
    r.end_time        = '0;
    r.waiting_time    = '0;
    r.turnaround_time = '0;
    if (found) begin
      if (tbl_remaining[pick] == tbl_burst[pick]) tbl_start[pick] = sched_time;
      tbl_remaining[pick] = tbl_remaining[pick] - 1'b1;
      r.running_slot = SLOT_W'(pick);
      r.running_id   = tbl_id[pick];
      if (tbl_remaining[pick] == '0) begin
        tbl_done[pick]    = 1'b1;
        r.finished        = 1'b1;
        r.start_time      = tbl_start[pick];
        r.end_time        = sched_time + 1;
        r.turnaround_time = r.end_time - CLK_W'(tbl_arrival[pick]);
        r.waiting_time    = r.turnaround_time - CLK_W'(tbl_burst[pick]);
      end
    end
    r.all_done = table_all_done();
    sched_time = sched_time + 1;
    return r;
  endfunction

  // Present one item and hold it until the transfer
  task automatic send_item(logic m, logic [SLOT_W-1:0] s, logic [ID_W-1:0] id,
                           logic [TIME_W-1:0] arr, logic [TIME_W-1:0] bl,
                           logic [PRIO_W-1:0] pr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    mode          <= m;
    slot          <= s;
    task_id       <= id;
    arrival_time  <= arr;
    burst_length  <= bl;
    task_priority <= pr;
    do @(posedge clk); while (!in_ready);
    n_items++;
    if (m == MODE_TICK) begin
      pending_reports.push_back(model_tick());
      n_ticks++;
    end else begin
      model_load(s, id, arr, bl, pr);
      n_loads++;
    end
  endtask

  task automatic send_tick();
    send_item(MODE_TICK, SLOT_W'($urandom_range(31)), ID_W'($urandom_range(255)),
              TIME_W'($urandom_range(65535)), TIME_W'($urandom_range(65535)),
              PRIO_W'($urandom_range(127)));
  endtask

  task automatic send_load(logic [SLOT_W-1:0] s, logic [ID_W-1:0] id,
                           logic [TIME_W-1:0] arr, logic [TIME_W-1:0] bl,
                           logic [PRIO_W-1:0] pr);
    send_item(MODE_LOAD, s, id, arr, bl, pr);
  endtask

  // Let the block go quiet, then write task_count
  task automatic set_task_count(logic [CNT_W-1:0] v);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sched_count = (v > MAX_TASKS) ? MAX_TASKS : v;
    n_cfg++;
  endtask

  // Load a task due soon; ties are likely when the priority set is narrow
  task automatic load_near_task(logic [SLOT_W-1:0] s, bit narrow_prio);
    int unsigned roll;
    logic [TIME_W-1:0] bl;
    roll = $urandom_range(99);
    if (roll < 5)       bl = '0;
    else if (roll < 90) bl = TIME_W'($urandom_range(5, 1));
    else                bl = TIME_W'($urandom_range(40, 6));
    send_load(s, ID_W'($urandom_range(255)),
              sched_time[TIME_W-1:0] + TIME_W'($urandom_range(12)), bl,
              narrow_prio ? PRIO_W'($urandom_range(3)) : PRIO_W'($urandom_range(127)));
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      n_errors++;
      if (n_errors <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // Receiver stalls
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // Compare each transferred report with the oldest prediction
  always @(posedge clk) begin
    tick_report_t want;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (pending_reports.size() == 0) begin
        n_errors++;
        if (n_errors <= REPORT_LIMIT)
          $display("%0t: report with no tick outstanding, time_now %0h", $time, time_now);
      end else begin
        want = pending_reports.pop_front();
        if (want.finished) n_completions++;
        if (want.idle) n_idle_ticks++;
        check_field("time_now",        want.time_now,          time_now);
        check_field("idle",            32'(want.idle),         32'(idle));
        check_field("running_slot",    32'(want.running_slot), 32'(running_slot));
        check_field("running_id",      32'(want.running_id),   32'(running_id));
        check_field("finished",        32'(want.finished),     32'(finished));
        check_field("start_time",      want.start_time,        start_time);
        check_field("end_time",        want.end_time,          end_time);
        check_field("waiting_time",    want.waiting_time,      waiting_time);
        check_field("turnaround_time", want.turnaround_time,   turnaround_time);
        check_field("all_done",        32'(want.all_done),     32'(all_done));
      end
    end
  end

  // No tasks in play: ticks are idle yet report all done
  task automatic test_empty_table();
    set_task_count('0);
    send_tick();
    send_tick();
  endtask

  // Park every slot with an arrival that is never reached
  task automatic fill_table();
    for (int s = 0; s < MAX_TASKS; s++)
      send_load(SLOT_W'(s), ID_W'($urandom_range(255)), '1,
                TIME_W'($urandom_range(65535)), PRIO_W'($urandom_range(127)));
  endtask

  // Tie on priority, late arrival preempting, zero burst, lowest priority
  task automatic test_priority_and_ties();
    logic [TIME_W-1:0] t;
    set_task_count(CNT_W'(4));
    t = sched_time[TIME_W-1:0];
    send_load(SLOT_W'(0), 8'h00, t,         TIME_W'(2), PRIO_W'(5));
    send_load(SLOT_W'(1), 8'h11, t,         TIME_W'(1), PRIO_W'(5));
    send_load(SLOT_W'(2), 8'hFF, t + 1'b1,  TIME_W'(1), PRIO_W'(0));
    send_load(SLOT_W'(3), 8'h33, '0,        '0,         PRIO_W'(127));
    repeat (6) send_tick();
  endtask

  // Oversized count, top slot, longest burst and reload mid-run
  task automatic test_count_limits();
    set_task_count('1);
    send_tick();
    send_load(SLOT_W'(31), 8'h80, '0, '1, PRIO_W'(100));
    send_tick();
    send_load(SLOT_W'(31), 8'h81, '0, TIME_W'(1), PRIO_W'(127));
    send_tick();
    set_task_count(CNT_W'(MAX_TASKS));
    send_tick();
  endtask

  // One workload: load the active slots, then tick until all finish or the cap is hit
  task automatic run_workload();
    int unsigned roll, n, cap, ticks;
    bit narrow;
    roll = $urandom_range(99);
    if (roll < 3)       n = 0;
    else if (roll < 73) n = $urandom_range(6, 1);
    else if (roll < 90) n = $urandom_range(16, 7);
    else                n = $urandom_range(32, 17);
    set_task_count((n == MAX_TASKS) ? CNT_W'($urandom_range(63, 32)) : CNT_W'(n));
    narrow = 1'($urandom_range(1));
    for (int s = 0; s < n; s++) load_near_task(SLOT_W'(s), narrow);
    cap = 16;
    for (int s = 0; s < n; s++) cap += tbl_remaining[s];
    ticks = 0;
    while (ticks < cap && !table_all_done()) begin
      // Occasionally reload a live slot, or drop a fully random load in
      if ($urandom_range(9) == 0) begin
        if (n != 0 && $urandom_range(4) < 3)
          load_near_task(SLOT_W'($urandom_range(n - 1)), narrow);
        else
          send_load(SLOT_W'($urandom_range(31)), ID_W'($urandom_range(255)),
                    TIME_W'($urandom_range(65535)), TIME_W'($urandom_range(65535)),
                    PRIO_W'($urandom_range(127)));
      end
      send_tick();
      ticks++;
    end
    repeat ($urandom_range(3, 1)) send_tick();
  endtask

  task automatic test_random_workloads(int send_pct, int recv_pct);
    int target;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    target = n_items + PHASE_ITEMS;
    while (n_items < target) run_workload();
  endtask

  initial begin
    rst           <= 1'b1;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    in_valid      <= 1'b0;
    mode          <= MODE_LOAD;
    slot          <= '0;
    task_id       <= '0;
    arrival_time  <= '0;
    burst_length  <= '0;
    task_priority <= '0;
    for (int i = 0; i < MAX_TASKS; i++) tbl_done[i] = 1'b0;
    sched_time  = '0;
    sched_count = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    fill_table();
    test_priority_and_ties();
    test_count_limits();
    test_random_workloads(29, 57);
    test_random_workloads(57, 29);
    test_random_workloads(0, 0);

    // Drain outstanding reports
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d loads and %0d ticks across %0d task_count writes.",
             n_loads, n_ticks, n_cfg);
    $display("Checked %0d reports: %0d completions, %0d idle ticks, %0d mismatches.",
             n_results, n_completions, n_idle_ticks, n_errors);
    if (n_errors == 0 && pending_reports.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
